// ----- rtl/core/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptc_pkg: shared definitions for the compensation core
// Register indexes, reset values, the calibration coefficient bundle and the
// request format passed from the front stage through the queue to the back.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegTempCoeffs   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPressCoeffsA = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPressCoeffsB = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPressCoeffP9 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTempOffset   = 3'd4;

  localparam logic signed [10:0] TempOffsetRst = -11'sd300;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Unpacked calibration coefficients.
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic signed [10:0] t_off;
  } coef_t;

  // Request as prepared by the front stage.
  typedef struct packed {
    logic signed [17:0] dt_lin;  // (adc_t >> 3) - 2*T1
    logic signed [16:0] dt_sq;   // (adc_t >> 4) - T1
    logic        [20:0] p_raw;   // 2^20 - adc_p
  } item_t;

endpackage

// ----- rtl/core/ptc_front.sv -----
// ----------------------------------------------------------------------------
// ptc_front: input stage
// Accepts a raw reading pair, forms the temperature differences and the
// inverted pressure reading, and hands the request to the queue.
// ----------------------------------------------------------------------------
module ptc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [19:0]         raw_press_i,
  input  logic [19:0]         raw_temp_i,
  input  logic [15:0]         coef_t1_i,
  input  logic                q_full_i,
  output logic                push_o,
  output ptc_pkg::item_t      item_o
);

  logic           hold_q;
  logic           hold_d;
  logic           accept;
  ptc_pkg::item_t item_q;
  ptc_pkg::item_t item_d;

  assign push_o     = hold_q && !q_full_i;
  assign in_stall_o = hold_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign item_o     = item_q;

  always_comb begin
    item_d.dt_lin = 18'($signed({1'b0, raw_temp_i[19:3]}) - $signed({1'b0, coef_t1_i, 1'b0}));
    item_d.dt_sq  = 17'($signed({1'b0, raw_temp_i[19:4]}) - $signed({1'b0, coef_t1_i}));
    item_d.p_raw  = 21'h100000 - {1'b0, raw_press_i};
  end

  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d = 1'b1;
    end else if (push_o) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

// ----- rtl/core/ptc_queue.sv -----
// ----------------------------------------------------------------------------
// ptc_queue: short request queue
// Two-entry FIFO that decouples the front stage from the back pipeline.
// ----------------------------------------------------------------------------
module ptc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ptc_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output ptc_pkg::item_t item_o
);

  ptc_pkg::item_t                    mem_q [ptc_pkg::QueueDepth];
  logic [ptc_pkg::QueuePtrW-1:0]     wr_q;
  logic [ptc_pkg::QueuePtrW-1:0]     wr_d;
  logic [ptc_pkg::QueuePtrW-1:0]     rd_q;
  logic [ptc_pkg::QueuePtrW-1:0]     rd_d;
  logic [ptc_pkg::QueueCntW-1:0]     cnt_q;
  logic [ptc_pkg::QueueCntW-1:0]     cnt_d;

  assign full_o  = (cnt_q == ptc_pkg::QueueCntW'(ptc_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == ptc_pkg::QueuePtrW'(ptc_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == ptc_pkg::QueuePtrW'(ptc_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/core/ptc_back.sv -----
// ----------------------------------------------------------------------------
// ptc_back: compensation pipeline
// Temperature terms, pressure polynomial, a one-bit-per-stage divider and
// the final pressure correction. The whole pipeline advances together and
// holds while a finished result is stalled at the output register.
// ----------------------------------------------------------------------------
module ptc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptc_pkg::coef_t     coef_i,
  input  logic               q_empty_i,
  input  ptc_pkg::item_t     item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] temp_centi_o,
  output logic        [24:0] press_q8_o,
  output logic signed [31:0] fine_temp_o,
  output logic               div_zero_o
);

  localparam int unsigned FrontStages = 12;
  localparam int unsigned DivSteps    = 64;
  localparam int unsigned TailStages  = 7;
  localparam int unsigned SideStages  = 9;
  localparam int unsigned RawStages   = 8;

  typedef struct packed {
    logic signed [14:0] temp;
    logic signed [24:0] tf;
    logic               dz;
  } side_t;

  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] num;
    logic [30:0] dvs;
    logic        neg;
    side_t       sd;
  } div_t;

  logic adv;

  logic [FrontStages-1:0] bv_q;
  logic [DivSteps-1:0]    dv_q;
  logic [TailStages-1:0]  ev_q;

  // Front part of the pipeline
  logic signed [33:0] m_lin_q;
  logic        [32:0] dsq_q;
  logic signed [22:0] ta_q;
  logic signed [37:0] m3_q;
  logic signed [24:0] tf3_q;
  logic signed [23:0] pa_q;
  logic        [45:0] asq_q;
  logic signed [39:0] ap5_q, ap2_q;
  logic signed [39:0] l6_q, h6_q, l3_q, h3_q, ap5b_q, ap2b_q;
  logic signed [63:0] x6_q, x3_q;
  logic signed [39:0] ap5c_q, ap2c_q;
  logic signed [63:0] bsum_q;
  logic signed [55:0] xs_q;
  logic        [43:0] lp_q;
  logic signed [44:0] hp_q;
  logic        [63:0] nb_q;
  logic signed [30:0] dvr_q, dvr11_q;
  logic        [63:0] n125_q, num_q, nabs_q;
  logic        [30:0] dabs_q;
  logic               neg_q, dz11_q, dz12_q;
  logic        [20:0] praw_q [RawStages];
  side_t              side_q [SideStages];

  // Divider
  div_t div_q  [DivSteps];
  div_t div_in [DivSteps];

  // Tail part
  logic        [63:0] pe_q [5];
  logic signed [42:0] sl9_q;
  logic signed [40:0] sh9_q;
  logic signed [48:0] pl8_q, ph8_q;
  logic        [63:0] m1_q, bb_q, ll_q, bb4_q, m2_q, bb5_q, sum_q;
  logic        [31:0] lh_q, hl_q;
  logic        [24:0] press_q;
  side_t              eside_q [TailStages];

  // Combinational helpers
  logic signed [33:0] dsq_full;
  logic signed [23:0] tb;
  logic signed [24:0] tf_sum;
  logic signed [28:0] t5;
  logic signed [20:0] tpre;
  logic signed [21:0] tsum;
  logic signed [14:0] temp_sat;
  logic signed [25:0] pa_full;
  logic signed [47:0] asq_full;
  logic signed [63:0] x3_sh, ap2_sh, ap5_sh, p4_sh, xs_full;
  logic        [63:0] prod_p1;
  logic signed [63:0] s64, m2_sh, bb_sh, sum_sh, p7_sh, fin_s;
  logic        [63:0] q_abs, p_e1;
  logic        [24:0] press_d;

  assign adv         = !(ev_q[TailStages-1] && out_stall_i);
  assign pop_o       = adv && !q_empty_i;
  assign out_valid_o = ev_q[TailStages-1];
  assign press_q8_o  = press_q;
  assign temp_centi_o = eside_q[TailStages-1].temp;
  assign fine_temp_o  = 32'(eside_q[TailStages-1].tf);
  assign div_zero_o   = eside_q[TailStages-1].dz;

  always_comb begin
    dsq_full = $signed(item_i.dt_sq) * $signed(item_i.dt_sq);
    tb       = 24'(m3_q >>> 14);
    tf_sum   = ta_q + tb;
    t5       = tf3_q * 29'sd5 + 29'sd128;
    tpre     = 21'(t5 >>> 8);
    tsum     = tpre + coef_i.t_off;
    if (tsum < -22'sd16384) begin
      temp_sat = -15'sd16384;
    end else if (tsum > 22'sd16383) begin
      temp_sat = 15'sd16383;
    end else begin
      temp_sat = 15'(tsum);
    end
    pa_full  = tf3_q - 26'sd128000;
    asq_full = pa_q * pa_q;
    x3_sh    = x3_q >>> 8;
    ap2_sh   = 64'(ap2c_q) <<< 12;
    ap5_sh   = 64'(ap5c_q) <<< 17;
    p4_sh    = 64'(coef_i.p4) <<< 35;
    xs_full  = x3_sh + ap2_sh + 64'sd140737488355328;
    prod_p1  = 64'(hp_q) <<< 28;
    prod_p1  = prod_p1 + 64'(lp_q);
  end

  // Divider input and steps
  always_comb begin
    div_in[0].rem = '0;
    div_in[0].num = nabs_q;
    div_in[0].dvs = dabs_q;
    div_in[0].neg = neg_q;
    div_in[0].sd  = side_q[SideStages-1];
    div_in[0].sd.dz = dz12_q;
  end

  for (genvar k = 1; k < DivSteps; k++) begin : g_div_link
    assign div_in[k] = div_q[k-1];
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [30:0] rem_sh;
    logic        ge;
    assign rem_sh = {div_in[k].rem[29:0], div_in[k].num[63]};
    assign ge     = (rem_sh >= div_in[k].dvs);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[k].rem <= ge ? rem_sh - div_in[k].dvs : rem_sh;
        div_q[k].num <= {div_in[k].num[62:0], ge};
        div_q[k].dvs <= div_in[k].dvs;
        div_q[k].neg <= div_in[k].neg;
        div_q[k].sd  <= div_in[k].sd;
      end
    end
  end

  // Tail helpers
  always_comb begin
    q_abs  = div_q[DivSteps-1].num;
    p_e1   = div_q[DivSteps-1].neg ? (~q_abs + 64'd1) : q_abs;
    s64    = 64'($signed(pe_q[2][63:13]));
    m2_sh  = $signed(m2_q) >>> 25;
    bb_sh  = $signed(bb5_q) >>> 19;
    sum_sh = $signed(sum_q) >>> 8;
    p7_sh  = 64'(coef_i.p7) <<< 4;
    fin_s  = sum_sh + p7_sh;
    if (eside_q[TailStages-2].dz || fin_s < 64'sd0) begin
      press_d = '0;
    end else if (fin_s > 64'sd33554431) begin
      press_d = '1;
    end else begin
      press_d = fin_s[24:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Temperature
      m_lin_q <= $signed(item_i.dt_lin) * $signed(coef_i.t2);
      dsq_q   <= dsq_full[32:0];
      praw_q[0] <= item_i.p_raw;
      ta_q    <= 23'(m_lin_q >>> 11);
      m3_q    <= $signed({1'b0, dsq_q[32:12]}) * $signed(coef_i.t3);
      tf3_q   <= tf_sum;
      pa_q    <= 24'(pa_full);
      side_q[0].temp <= temp_sat;
      side_q[0].tf   <= tf3_q;
      side_q[0].dz   <= 1'b0;
      // Pressure polynomial
      asq_q   <= asq_full[45:0];
      ap5_q   <= pa_q * coef_i.p5;
      ap2_q   <= pa_q * coef_i.p2;
      l6_q    <= $signed({1'b0, asq_q[22:0]}) * coef_i.p6;
      h6_q    <= $signed({1'b0, asq_q[45:23]}) * coef_i.p6;
      l3_q    <= $signed({1'b0, asq_q[22:0]}) * coef_i.p3;
      h3_q    <= $signed({1'b0, asq_q[45:23]}) * coef_i.p3;
      ap5b_q  <= ap5_q;
      ap2b_q  <= ap2_q;
      x6_q    <= (64'(h6_q) <<< 23) + 64'(l6_q);
      x3_q    <= (64'(h3_q) <<< 23) + 64'(l3_q);
      ap5c_q  <= ap5b_q;
      ap2c_q  <= ap2b_q;
      bsum_q  <= x6_q + ap5_sh + p4_sh;
      xs_q    <= 56'(xs_full);
      lp_q    <= 44'(xs_q[27:0]) * 44'(coef_i.p1);
      hp_q    <= $signed(xs_q[55:28]) * $signed({1'b0, coef_i.p1});
      nb_q    <= 64'({praw_q[RawStages-1], 31'd0}) - bsum_q;
      // Divider operands
      dvr_q   <= $signed(prod_p1[63:33]);
      n125_q  <= nb_q * 64'd125;
      dvr11_q <= dvr_q;
      num_q   <= n125_q * 64'd25;
      dz11_q  <= (dvr_q == '0);
      nabs_q  <= num_q[63] ? (~num_q + 64'd1) : num_q;
      dabs_q  <= dvr11_q[30] ? (~dvr11_q + 31'd1) : dvr11_q;
      neg_q   <= num_q[63] ^ dvr11_q[30];
      dz12_q  <= dz11_q;
      // Final pressure correction
      pe_q[0] <= p_e1;
      sl9_q   <= $signed({1'b0, pe_q[0][38:13]}) * coef_i.p9;
      sh9_q   <= $signed(pe_q[0][63:39]) * coef_i.p9;
      pl8_q   <= $signed({1'b0, pe_q[0][31:0]}) * coef_i.p8;
      ph8_q   <= $signed({1'b0, pe_q[0][63:32]}) * coef_i.p8;
      pe_q[1] <= pe_q[0];
      m1_q    <= (64'(sh9_q) << 26) + 64'(sl9_q);
      bb_q    <= (64'(ph8_q) << 32) + 64'(pl8_q);
      pe_q[2] <= pe_q[1];
      ll_q    <= 64'(m1_q[31:0]) * 64'(s64[31:0]);
      lh_q    <= 32'(m1_q[31:0] * s64[63:32]);
      hl_q    <= 32'(m1_q[63:32] * s64[31:0]);
      bb4_q   <= bb_q;
      pe_q[3] <= pe_q[2];
      m2_q    <= ll_q + {32'(lh_q + hl_q), 32'd0};
      bb5_q   <= bb4_q;
      pe_q[4] <= pe_q[3];
      sum_q   <= pe_q[4] + 64'(m2_sh) + 64'(bb_sh);
      press_q <= press_d;
      eside_q[0] <= div_q[DivSteps-1].sd;
      for (int i = 1; i < RawStages; i++) begin
        praw_q[i] <= praw_q[i-1];
      end
      for (int i = 1; i < SideStages; i++) begin
        side_q[i] <= side_q[i-1];
      end
      for (int i = 1; i < TailStages; i++) begin
        eside_q[i] <= eside_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
      dv_q <= '0;
      ev_q <= '0;
    end else if (adv) begin
      bv_q <= {bv_q[FrontStages-2:0], !q_empty_i};
      dv_q <= {dv_q[DivSteps-2:0], bv_q[FrontStages-1]};
      ev_q <= {ev_q[TailStages-2:0], dv_q[DivSteps-1]};
    end
  end

endmodule

// ----- rtl/core/pressure_temperature_compensation_core.sv -----
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core: sensor compensation core
// Integer temperature and pressure compensation from calibration registers.
// ----------------------------------------------------------------------------
// Usage:
// A request carries one raw pressure and one raw temperature reading on the
// input channel (in_valid_i / in_stall_o). Each request gives exactly one
// result on the output channel (out_valid_o / out_stall_i): temperature in
// hundredths of a degree, pressure in Pa with 8 fraction bits, the fine
// temperature value and a flag for a zero pressure divisor.
// The core takes one request per cycle while in_stall_o is low. The accepting
// edge loads the front register. The queue, twelve stages of coefficient
// arithmetic, 64 stages of the pipelined divider that retires one quotient
// bit per stage, and seven stages of final pressure correction ending in the
// output register follow in that order.
// When the receiver stalls, the whole back pipeline holds its contents while
// the queue and the front register keep taking up to three more requests;
// then in_stall_o rises. Nothing is lost or repeated.
// Reset clears all valid state and loads the register defaults (coefficients
// zero, temperature offset -3.00 degrees). Configuration writes are taken at
// any cycle but must only be made while no request is in flight.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [19:0]                    raw_press_i,
  input  logic [19:0]                    raw_temp_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [14:0]             temp_centi_o,
  output logic [24:0]                    press_q8_o,
  output logic signed [31:0]             fine_temp_o,
  output logic                           div_zero_o,
  input  logic                           cfg_we_i,
  input  logic [ptc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ptc_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  // Configuration registers
  logic [47:0]        temp_coeffs_q;
  logic [63:0]        press_a_q;
  logic [63:0]        press_b_q;
  logic [15:0]        p9_q;
  logic signed [10:0] t_off_q;

  ptc_pkg::coef_t coef;
  ptc_pkg::item_t front_item;
  ptc_pkg::item_t q_item;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_a_q     <= '0;
      press_b_q     <= '0;
      p9_q          <= '0;
      t_off_q       <= ptc_pkg::TempOffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ptc_pkg::RegTempCoeffs:   temp_coeffs_q <= cfg_wdata_i[47:0];
        ptc_pkg::RegPressCoeffsA: press_a_q     <= cfg_wdata_i;
        ptc_pkg::RegPressCoeffsB: press_b_q     <= cfg_wdata_i;
        ptc_pkg::RegPressCoeffP9: p9_q          <= cfg_wdata_i[15:0];
        ptc_pkg::RegTempOffset:   t_off_q       <= $signed(cfg_wdata_i[10:0]);
        default: begin
        end
      endcase
    end
  end

  // The packed words unpack into their 16-bit coefficients, lowest first.
  always_comb begin
    coef.t1    = temp_coeffs_q[15:0];
    coef.t2    = $signed(temp_coeffs_q[31:16]);
    coef.t3    = $signed(temp_coeffs_q[47:32]);
    coef.p1    = press_a_q[15:0];
    coef.p2    = $signed(press_a_q[31:16]);
    coef.p3    = $signed(press_a_q[47:32]);
    coef.p4    = $signed(press_a_q[63:48]);
    coef.p5    = $signed(press_b_q[15:0]);
    coef.p6    = $signed(press_b_q[31:16]);
    coef.p7    = $signed(press_b_q[47:32]);
    coef.p8    = $signed(press_b_q[63:48]);
    coef.p9    = $signed(p9_q);
    coef.t_off = t_off_q;
  end

  // The front register takes requests and prepares the temperature and
  // pressure differences.
  ptc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_press_i (raw_press_i),
    .raw_temp_i  (raw_temp_i),
    .coef_t1_i   (coef.t1),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (front_item)
  );

  // The queue lets the front keep accepting while the back pipeline holds.
  ptc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  // The back pipeline does the compensation arithmetic and owns the output register.
  ptc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coef_i       (coef),
    .q_empty_i    (q_empty),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .temp_centi_o (temp_centi_o),
    .press_q8_o   (press_q8_o),
    .fine_temp_o  (fine_temp_o),
    .div_zero_o   (div_zero_o)
  );

endmodule
